@@ src/assert_macros.svh @@
// Assertion macros shared by the rolling hash trigger modules.
// Included by every module that checks its own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define RHPT_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
		else $error("rhpt: assertion failed");
// Check that a condition is never true outside reset.
`define RHPT_NEVER(lbl, clk_i, rstn_i, cond) \
	`RHPT_ASSERT(lbl, clk_i, rstn_i, !(cond))
`else
`define RHPT_ASSERT(lbl, clk_i, rstn_i, prop)
`define RHPT_NEVER(lbl, clk_i, rstn_i, cond)
`endif
`endif

@@ src/rhpt_pkg.sv @@
// Types and constants of the rolling hash phrase trigger.
// No dependencies; imported by every module of the block but rhpt_ram.
package rhpt_pkg;

	localparam int unsigned MAX_WINDOW = 64;
	localparam int unsigned RING_AW    = $clog2(MAX_WINDOW);
	localparam int unsigned WIN_W      = 7;
	localparam int unsigned HASH_W     = 31;
	localparam int unsigned BYTE_W     = 8;
	// Effective window must hold MAX_WINDOW itself.
	localparam int unsigned EFF_W      = (RING_AW + 1 > WIN_W) ? RING_AW + 1 : WIN_W;
	// One power step is a multiply by 256, done as 8 modular doublings.
	localparam int unsigned POW_CNT_W  = EFF_W + 3;
	localparam int unsigned CNT_W      = $clog2(HASH_W);
	localparam int unsigned QDEPTH     = 2;
	localparam int unsigned QAW        = $clog2(QDEPTH);

	localparam logic [HASH_W-1:0] PRIME     = 31'd1999999973;
	localparam logic [WIN_W-1:0]  WIN_RESET = 7'd10;
	localparam logic [HASH_W-1:0] DIV_RESET = 31'd100;

	typedef enum logic [0:0] {
		REG_WINDOW  = 1'b0,
		REG_DIVISOR = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              restart;
	} in_item_t;

	typedef struct packed {
		logic [HASH_W-1:0] window_hash;
		logic              boundary;
	} out_item_t;

	typedef struct packed {
		logic              win_wr;
		logic              div_wr;
		logic [HASH_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} hash_xfer_t;

endpackage

@@ src/rhpt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the byte ring of the hash window.
module rhpt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/rhpt_front.sv @@
// Front end: accepts bytes, keeps the window ring and the running Karp-Rabin hash.
// Depends on rhpt_pkg, rhpt_ram and assert_macros.svh.
`include "assert_macros.svh"
module rhpt_front import rhpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	input  cfg_wr_t    cfg,
	output hash_xfer_t push,
	input  logic       push_ready
);

	typedef enum logic [2:0] {
		F_POW, F_IDLE, F_READ, F_MUL, F_SUB, F_SHIFT, F_PUSH
	} fstate_t;

	function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b);
		logic [HASH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[HASH_W-1:0];
	endfunction

	// 2*a + b mod prime
	function automatic logic [HASH_W-1:0] shift_mod(input logic [HASH_W-1:0] a,
			input logic b);
		logic [HASH_W:0] s;
		s = {a, b};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[HASH_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b);
		logic [HASH_W-1:0] r;
		if (a >= b) begin
			r = a - b;
		end else begin
			r = a + (PRIME - b);
		end
		return r;
	endfunction

	function automatic logic [EFF_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
		logic [EFF_W-1:0] w;
		w = EFF_W'(ws);
		if (w == '0) begin
			w = EFF_W'(1);
		end
		if (w > EFF_W'(MAX_WINDOW)) begin
			w = EFF_W'(MAX_WINDOW);
		end
		return w;
	endfunction

	function automatic logic [POW_CNT_W-1:0] pow_steps(input logic [EFF_W-1:0] w);
		logic [EFF_W-1:0] m;
		m = w - EFF_W'(1);
		return {m, 3'b000};
	endfunction

	fstate_t              state_q;
	logic [WIN_W-1:0]     win_q;
	logic [HASH_W-1:0]    tp_q;
	logic [HASH_W-1:0]    hash_q;
	logic [HASH_W-1:0]    acc_q;
	logic [POW_CNT_W-1:0] pcnt_q;
	logic [RING_AW-1:0]   idx_q;
	logic [RING_AW-1:0]   k_q;
	logic [MAX_WINDOW-1:0] vld_q;
	logic [BYTE_W-1:0]    byte_q;
	logic [BYTE_W-1:0]    old_q;
	logic [2:0]           step_q;

	logic [EFF_W-1:0]     w_eff;
	logic [RING_AW-1:0]   k_base;
	logic [RING_AW-1:0]   k_new;
	logic [EFF_W-1:0]     k_inc;
	logic [RING_AW-1:0]   idx_next;
	logic [BYTE_W-1:0]    ring_rdata;
	logic                 ring_we;
	logic [HASH_W-1:0]    mul_next;
	logic [HASH_W-1:0]    dbl_acc;

	assign w_eff    = eff_window(win_q);
	assign in_ready = (state_q == F_IDLE) && !cfg.win_wr;
	assign ring_we  = (state_q == F_PUSH) && push_ready;
	assign push.valid = (state_q == F_PUSH);
	assign push.hash  = acc_q;

	// Slot of the outgoing byte; a shrunken window wraps back to slot 0.
	always_comb begin
		k_base = in_item.restart ? '0 : idx_q;
		k_new  = (EFF_W'(k_base) >= w_eff) ? '0 : k_base;
		k_inc  = EFF_W'(k_q) + EFF_W'(1);
		idx_next = (k_inc >= w_eff) ? '0 : k_inc[RING_AW-1:0];
	end

	// One MSB-first step of outgoing byte times top power.
	always_comb begin
		dbl_acc  = shift_mod(acc_q, 1'b0);
		mul_next = old_q[step_q] ? add_mod(dbl_acc, tp_q) : dbl_acc;
	end

	rhpt_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (k_q),
		.wdata (byte_q),
		.raddr (k_new),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_POW;
			win_q   <= WIN_RESET;
			tp_q    <= HASH_W'(1);
			pcnt_q  <= pow_steps(eff_window(WIN_RESET));
			hash_q  <= '0;
			idx_q   <= '0;
			vld_q   <= '0;
		end else if (cfg.win_wr) begin
			win_q   <= cfg.data[WIN_W-1:0];
			tp_q    <= HASH_W'(1);
			pcnt_q  <= pow_steps(eff_window(cfg.data[WIN_W-1:0]));
			state_q <= F_POW;
		end else begin
			case (state_q)
				F_POW: begin
					if (pcnt_q == '0) begin
						state_q <= F_IDLE;
					end else begin
						tp_q   <= add_mod(tp_q, tp_q);
						pcnt_q <= pcnt_q - POW_CNT_W'(1);
					end
				end
				F_IDLE: begin
					if (in_valid) begin
						byte_q <= in_item.byte_in;
						k_q    <= k_new;
						if (in_item.restart) begin
							vld_q  <= '0;
							hash_q <= '0;
						end
						state_q <= F_READ;
					end
				end
				F_READ: begin
					old_q   <= vld_q[k_q] ? ring_rdata : '0;
					acc_q   <= '0;
					step_q  <= 3'd7;
					state_q <= F_MUL;
				end
				F_MUL: begin
					acc_q  <= mul_next;
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) begin
						state_q <= F_SUB;
					end
				end
				F_SUB: begin
					acc_q   <= sub_mod(hash_q, acc_q);
					step_q  <= 3'd7;
					state_q <= F_SHIFT;
				end
				F_SHIFT: begin
					acc_q  <= shift_mod(acc_q, byte_q[step_q]);
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						hash_q     <= acc_q;
						vld_q[k_q] <= 1'b1;
						idx_q      <= idx_next;
						state_q    <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	`RHPT_NEVER(a_hash_range, clk, arst_n, hash_q >= PRIME)
	`RHPT_NEVER(a_power_range, clk, arst_n, tp_q >= PRIME)
	`RHPT_ASSERT(a_slot_marked, clk, arst_n, ring_we |=> vld_q[$past(k_q)])

endmodule

@@ src/rhpt_queue.sv @@
// Short hash queue between the front end and the remainder unit.
// Depends on rhpt_pkg.
module rhpt_queue import rhpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hash_xfer_t push,
	output logic       push_ready,
	output hash_xfer_t pop,
	input  logic       pop_ready
);

	logic [HASH_W-1:0] mem_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW:0]      cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop.valid  = (cnt_q != '0);
	assign pop.hash   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop.valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.hash;
		end
	end

	// Pointers wrap naturally: depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/rhpt_back.sv @@
// Back end: bit-serial remainder of the hash by the trigger divisor, output register.
// Depends on rhpt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rhpt_back import rhpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hash_xfer_t pop,
	output logic       pop_ready,
	input  cfg_wr_t    cfg,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item
);

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_DONE} bstate_t;

	bstate_t           state_q;
	logic [HASH_W-1:0] div_q;
	logic [HASH_W-1:0] dv_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] num_q;
	logic [HASH_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [HASH_W:0]   trial;
	logic [HASH_W-1:0] rem_next;

	assign pop_ready = (state_q == B_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		trial    = {rem_q, num_q[HASH_W-1]};
		rem_next = (trial >= {1'b0, dv_q}) ? HASH_W'(trial - {1'b0, dv_q})
				: trial[HASH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			div_q       <= DIV_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.div_wr) begin
				div_q <= cfg.data;
			end
			// Drop the taken item unless a new one is loaded in this cycle.
			if (out_valid_q && out_ready && state_q != B_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop.valid) begin
						hash_q  <= pop.hash;
						num_q   <= pop.hash;
						rem_q   <= '0;
						dv_q    <= div_q;
						cnt_q   <= CNT_W'(HASH_W - 1);
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					rem_q <= rem_next;
					num_q <= {num_q[HASH_W-2:0], 1'b0};
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				B_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_q.window_hash <= hash_q;
						out_q.boundary    <= (dv_q != '0) && (rem_q == '0);
						state_q           <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	`RHPT_ASSERT(a_rem_bound, clk, arst_n, (state_q == B_RUN && dv_q != '0) |-> rem_q < dv_q)
	`RHPT_ASSERT(a_pop_starts, clk, arst_n, (pop.valid && pop_ready) |=> state_q == B_RUN)
	`RHPT_ASSERT(a_done_waits, clk, arst_n,
		(state_q == B_DONE && out_valid_q && !out_ready) |=> (state_q == B_DONE && out_valid_q))

endmodule

@@ src/rolling_hash_phrase_trigger_top.sv @@
// Top level of the rolling Karp-Rabin hash phrase trigger.
// Depends on rhpt_pkg, rhpt_front, rhpt_queue and rhpt_back.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid / in_ready    | in_item  (byte_in, restart)
//  out      | output    | out_valid / out_ready  | out_item (window_hash, boundary)
//  cfg      | input     | cfg_we, no wait        | cfg_index, cfg_wdata
//
// Sustained throughput is set by the back end's remainder unit, which loads a hash,
// retires one dividend bit per cycle and hands off the result before it takes
// another. Per item the front end does a ring read, 8 multiply steps, one subtract
// and 8 shift-in steps, each a modular add on the 31-bit hash. After reset and after
// each window write the front end computes the top power by repeated modular
// doubling and holds in_ready low. A full queue stalls only the front end; a stalled
// output register stalls the back end, and the front end too once the queue fills.
module rolling_hash_phrase_trigger_top import rhpt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	input  logic              cfg_we,
	input  reg_idx_t          cfg_index,
	input  logic [HASH_W-1:0] cfg_wdata
);

	cfg_wr_t    cfg_wr;
	hash_xfer_t fe_push;
	logic       fe_push_ready;
	hash_xfer_t be_pop;
	logic       be_pop_ready;

	// Decode the register index into one write strobe per register.
	always_comb begin
		cfg_wr.win_wr = cfg_we && (cfg_index == REG_WINDOW);
		cfg_wr.div_wr = cfg_we && (cfg_index == REG_DIVISOR);
		cfg_wr.data   = cfg_wdata;
	end

	// Accept bytes, roll the window and the hash.
	rhpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.cfg        (cfg_wr),
		.push       (fe_push),
		.push_ready (fe_push_ready)
	);

	// Hold finished hashes until the remainder unit is free.
	rhpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fe_push),
		.push_ready (fe_push_ready),
		.pop        (be_pop),
		.pop_ready  (be_pop_ready)
	);

	// Reduce each hash by the divisor and present the item.
	rhpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (be_pop),
		.pop_ready (be_pop_ready),
		.cfg       (cfg_wr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

@@ sim/tb_rolling_hash_phrase_trigger_top.sv @@
// Testbench for rolling_hash_phrase_trigger_top: byte stream in, rolling hash and boundary out.
// Depends on rhpt_pkg and the block's RTL; checks every result against a built-in hash predictor.
module tb_rolling_hash_phrase_trigger_top;
	import rhpt_pkg::*;

	// Run limits and waits; all but RANDOM_ITEMS in clock cycles
	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned SETTLE_CYCLES  = 60;    // quiet time after the queue drains
	localparam int unsigned RX_HOLD_CYCLES = 1200;  // long receiver hold-off
	localparam int unsigned RANDOM_ITEMS   = 1550;

	localparam longint unsigned KR_MOD  = PRIME;
	localparam longint unsigned KR_BASE = 256;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_item_t          in_item;
	logic              out_valid;
	logic              out_ready;
	out_item_t         out_item;
	logic              cfg_we;
	reg_idx_t          cfg_index;
	logic [HASH_W-1:0] cfg_wdata;

	// Predictor state: window bytes, slot of the outgoing byte, hash, top power
	logic [BYTE_W-1:0] win_bytes [MAX_WINDOW];
	int unsigned       slot_ptr;
	longint unsigned   hash_acc;
	longint unsigned   pow_top;
	logic [WIN_W-1:0]  win_cfg;
	logic [HASH_W-1:0] div_cfg;

	// Results still owed by the block, oldest first
	out_item_t   hash_expect_q [$];
	out_item_t   oldest_hash;
	int unsigned err_cnt;
	int unsigned items_sent;
	int unsigned cycle_cnt;
	bit          idle_on;
	bit          rx_hold_req;

	rolling_hash_phrase_trigger_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs or crawls
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Hash predictor
	// ------------------------------------------------------------------

	// Saturate the programmed window to 1..MAX_WINDOW
	function automatic int unsigned eff_window();
		int unsigned w;
		w = 32'(win_cfg);
		if (w < 1) w = 1;
		if (w > MAX_WINDOW) w = MAX_WINDOW;
		return w;
	endfunction

	// 256^(W-1) mod prime, weight of the byte about to leave the window
	function automatic void refresh_power();
		int unsigned     w;
		int unsigned     i;
		longint unsigned p;
		w = eff_window();
		p = 1;
		for (i = 1; i < w; i++)
			p = (p * KR_BASE) % KR_MOD;
		pow_top = p;
	endfunction

	function automatic void predictor_reset();
		win_cfg = WIN_RESET;
		div_cfg = DIV_RESET;
		foreach (win_bytes[i]) win_bytes[i] = '0;
		slot_ptr = 0;
		hash_acc = 0;
		refresh_power();
	endfunction

	// Roll one byte into the window and return the hash and boundary it yields
	function automatic out_item_t hash_predict(input in_item_t it);
		int unsigned     w;
		int unsigned     k;
		longint unsigned removed;
		longint unsigned h;
		out_item_t       r;
		w = eff_window();
		if (it.restart) begin
			foreach (win_bytes[i]) win_bytes[i] = '0;
			slot_ptr = 0;
			hash_acc = 0;
		end
		// a shrunken window can leave the pointer past its end: wrap to slot 0
		k = slot_ptr;
		if (k >= w) k = 0;
		removed = (longint'(win_bytes[k]) * pow_top) % KR_MOD;
		h = hash_acc + KR_MOD - removed;
		h = (KR_BASE * h + it.byte_in) % KR_MOD;
		hash_acc = h;
		win_bytes[k] = it.byte_in;
		k++;
		if (k >= w) k = 0;
		slot_ptr = k;
		r.window_hash = h[HASH_W-1:0];
		// a zero divisor never flags a boundary
		if (div_cfg == 0)
			r.boundary = 1'b0;
		else
			r.boundary = ((h % longint'(div_cfg)) == 0);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic in_item_t mk_item(input logic [BYTE_W-1:0] b, input logic rs);
		in_item_t r;
		r.byte_in = b;
		r.restart = rs;
		return r;
	endfunction

	// Random byte with a bias toward the extremes, and an occasional restart
	function automatic in_item_t rand_item();
		in_item_t r;
		case ($urandom_range(0, 15))
			0:       r.byte_in = '0;
			1:       r.byte_in = '1;
			default: r.byte_in = BYTE_W'($urandom_range(0, 255));
		endcase
		r.restart = ($urandom_range(0, 31) == 0);
		return r;
	endfunction

	// Offer one item, hold it until accepted, then log what it must produce.
	// Returns at the accepting edge with in_valid still high.
	task automatic send_item(input in_item_t it);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		hash_expect_q = {hash_expect_q, hash_predict(it)};
		items_sent++;
	endtask

	// Drop valid so the last item is not offered again
	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (hash_expect_q.size() != 0) @(posedge clk);
	endtask

	// Write a register once the block has gone quiet
	task automatic write_reg(input reg_idx_t idx, input logic [HASH_W-1:0] val);
		release_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_WINDOW: begin
				win_cfg = val[WIN_W-1:0];
				refresh_power();
			end
			REG_DIVISOR: div_cfg = val;
			default: ;
		endcase
	endtask

	// Window write with junk above the register's seven bits
	task automatic write_window(input int unsigned w);
		logic [HASH_W-1:0] val;
		val = HASH_W'($urandom());
		val[WIN_W-1:0] = w[WIN_W-1:0];
		write_reg(REG_WINDOW, val);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: each accepted item against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hash_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result, expected none, actual hash %0d boundary %0b",
					$time, out_item.window_hash, out_item.boundary);
			end else begin
				oldest_hash = hash_expect_q.pop_front();
				if (out_item.window_hash !== oldest_hash.window_hash) begin
					err_cnt++;
					$display("%0t: window_hash mismatch, expected %0d, actual %0d",
						$time, oldest_hash.window_hash, out_item.window_hash);
				end
				if (out_item.boundary !== oldest_hash.boundary) begin
					err_cnt++;
					$display("%0t: boundary mismatch, expected %0b, actual %0b",
						$time, oldest_hash.boundary, out_item.boundary);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: window 10, divisor 100. A restart with byte zero gives
	// hash zero, which every nonzero divisor flags as a boundary.
	task automatic test_reset_settings();
		send_item(mk_item(8'h00, 1'b1));
		send_item(mk_item(8'hFF, 1'b0));
		send_item(mk_item(8'hFF, 1'b0));
		send_item(mk_item(8'h00, 1'b0));
		send_item(mk_item(8'hA5, 1'b1));
		send_item(mk_item(8'h5A, 1'b0));
	endtask

	// Window at its limits and beyond: 1, MAX_WINDOW, 0 (acts as 1) and
	// 127, a value above MAX_WINDOW (saturates)
	task automatic test_window_limits();
		write_window(1);
		send_item(mk_item(8'hFF, 1'b0));
		send_item(mk_item(8'h01, 1'b0));
		write_window(MAX_WINDOW);
		send_item(mk_item(8'h80, 1'b0));
		send_item(mk_item(8'h7F, 1'b0));
		write_window(0);
		send_item(mk_item(8'hFF, 1'b0));
		send_item(mk_item(8'hFE, 1'b0));
		write_window(127);
		send_item(mk_item(8'h00, 1'b1));
		send_item(mk_item(8'hFF, 1'b0));
	endtask

	// Shrink the window under a pointer that sits past its new end: the ring
	// and hash are kept and the next byte goes to slot zero
	task automatic test_window_shrink();
		send_item(mk_item(8'h11, 1'b0));
		send_item(mk_item(8'h22, 1'b0));
		send_item(mk_item(8'h33, 1'b0));
		send_item(mk_item(8'h44, 1'b0));
		send_item(mk_item(8'h55, 1'b0));
		write_window(2);
		send_item(mk_item(8'h66, 1'b0));
		send_item(mk_item(8'h77, 1'b0));
	endtask

	// Divisor zero never flags; one flags always; full-width divisor
	task automatic test_divisor_limits();
		write_reg(REG_DIVISOR, '0);
		send_item(mk_item(8'h00, 1'b1));
		write_reg(REG_DIVISOR, 31'd1);
		send_item(mk_item(8'hC3, 1'b0));
		write_reg(REG_DIVISOR, '1);
		send_item(mk_item(8'h00, 1'b1));
	endtask

	// Random phases, each with its own window and divisor. Small divisors keep
	// boundaries frequent; small windows keep the power pass short.
	task automatic test_random_phases();
		int unsigned target;
		int unsigned n;
		int unsigned w;
		logic [HASH_W-1:0] d;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0:       w = 0;
				1:       w = MAX_WINDOW;
				2:       w = $urandom_range(MAX_WINDOW + 1, 127);
				3:       w = $urandom_range(17, MAX_WINDOW - 1);
				default: w = $urandom_range(1, 16);
			endcase
			case ($urandom_range(0, 9))
				0:       d = '0;
				1:       d = 31'd1;
				2:       d = '1;
				3:       d = HASH_W'($urandom());
				default: d = HASH_W'($urandom_range(2, 24));
			endcase
			write_window(w);
			write_reg(REG_DIVISOR, d);
			// leave some phases free of idling on both sides
			idle_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(60, 150);
			repeat (n) send_item(rand_item());
		end
		idle_on = 1'b1;
	endtask

	// Hold the receiver off while the sender keeps offering, so the block
	// fills and drops in_ready; then pause until everything has come out
	task automatic test_backpressure();
		idle_on = 1'b0;
		rx_hold_req = 1'b1;
		repeat (16) send_item(rand_item());
		release_input();
		wait_drained();
		idle_on = 1'b1;
	endtask

	// Back-to-back items with no idling at all
	task automatic test_full_rate();
		write_window($urandom_range(3, 12));
		write_reg(REG_DIVISOR, HASH_W'($urandom_range(2, 10)));
		idle_on = 1'b0;
		repeat (110) send_item(rand_item());
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_item     = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_WINDOW;
		cfg_wdata   = '0;
		err_cnt     = 0;
		items_sent  = 0;
		idle_on     = 1'b1;
		rx_hold_req = 1'b0;
		predictor_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_window_limits();
		test_window_shrink();
		test_divisor_limits();
		test_random_phases();
		test_backpressure();
		test_full_rate();

		// drain, then give the pipeline time to show any stray result
		release_input();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ rolling_hash_phrase_trigger_top.f @@
+incdir+src
src/rhpt_pkg.sv
src/rhpt_ram.sv
src/rhpt_front.sv
src/rhpt_queue.sv
src/rhpt_back.sv
src/rolling_hash_phrase_trigger_top.sv
sim/tb_rolling_hash_phrase_trigger_top.sv
